[hdl/ffa_pkg.sv]
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int DEF_HEAP_BYTES = 1048576;
  localparam int DEF_MAX_BLOCKS = 64;
  localparam logic [5:0] HDR_RESET = 6'd12;

  typedef enum logic [1:0] {
    OPC_ALLOC = 2'd0,
    OPC_FREE  = 2'd1,
    OPC_CLEAR = 2'd2,
    OPC_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_ZERO,
    CMD_FREE,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [21:0] need;
    logic [19:0] offset;
  } cmd_t;

  typedef struct packed {
    logic [19:0] start;
    logic [20:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_APPEND,
    S_IS_RD,
    S_IS_WR,
    S_SPLIT1,
    S_SPLIT2,
    S_F_RD,
    S_F_CHK,
    S_M_RD0,
    S_M_LD,
    S_M_CHK,
    S_M_NXT,
    S_RM_RD,
    S_RM_WR,
    S_DONE
  } state_t;

endpackage

[hdl/ffa_ram.sv]
`timescale 1ns / 1ps
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ffa_fifo.sv]
`timescale 1ns / 1ps
module ffa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

[hdl/ffa_front.sv]
`timescale 1ns / 1ps
module ffa_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    opcode,
  input  logic [20:0]   request_bytes,
  input  logic [19:0]   free_offset,
  output logic          cmd_push,
  output ffa_pkg::cmd_t cmd,
  input  logic          cmd_full
);
  import ffa_pkg::*;

  logic        vld;
  cmd_t        cls;
  logic [21:0] need;

  // round up to a multiple of 8
  assign need = ({1'b0, request_bytes} + 22'd7) & ~22'd7;

  always_comb begin
    cls.need   = need;
    cls.offset = free_offset;
    case (opcode_t'(opcode))
      OPC_ALLOC: cls.kind = (need == '0) ? CMD_ZERO : CMD_ALLOC;
      OPC_FREE:  cls.kind = CMD_FREE;
      OPC_CLEAR: cls.kind = CMD_CLEAR;
      default:   cls.kind = CMD_NOP;
    endcase
  end

  assign full     = vld && cmd_full;
  assign cmd_push = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (push && !full) begin
      vld <= 1'b1;
    end else if (!cmd_full) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      cmd <= cls;
    end
  end

endmodule

[hdl/ffa_back.sv]
`timescale 1ns / 1ps
module ffa_back #(
  parameter int HEAP_BYTES = ffa_pkg::DEF_HEAP_BYTES,
  parameter int MAX_BLOCKS = ffa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [5:0]                        hdr,
  input  logic                              cmd_empty,
  output logic                              cmd_pop,
  input  ffa_pkg::cmd_t                     cmd,
  input  logic                              res_full,
  output logic                              res_push,
  output ffa_pkg::status_t                  res_status,
  output logic [19:0]                       res_payload,
  output logic [31:0]                       res_ops,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]   res_blocks
);
  import ffa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [22:0] HEAP_LIM = 23'(HEAP_BYTES);
  localparam logic [CW:0] MAX_W = (CW+1)'(MAX_BLOCKS);

  state_t        state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] k, k_next;
  logic [CW-1:0] n, n_next;
  logic [20:0]   heap_top, heap_top_next;
  logic [31:0]   ops, ops_next;
  entry_t        cur, cur_next;
  cmd_t          cm, cm_next;
  status_t       st, st_next;
  logic [19:0]   pay, pay_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic [CW:0]   n_w, idx_p1, idx_p2, k_p2, k_m1;
  logic [22:0]   app_end;
  logic [21:0]   adj_end;
  logic [20:0]   merged;

  ffa_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n_w     = (CW+1)'(n);
  assign idx_p1  = (CW+1)'(idx) + 1'b1;
  assign idx_p2  = (CW+1)'(idx) + 2'd2;
  assign k_p2    = (CW+1)'(k) + 2'd2;
  assign k_m1    = (CW+1)'(k) - 1'b1;
  assign app_end = 23'(heap_top) + 23'(hdr) + 23'(cm.need);
  assign adj_end = 22'(cur.start) + 22'(hdr) + 22'(cur.size);
  assign merged  = cur.size + 21'(hdr) + rdata.size;

  assign res_status  = st;
  assign res_payload = pay;
  assign res_ops     = ops;
  assign res_blocks  = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      n        <= '0;
      heap_top <= '0;
      ops      <= '0;
    end else begin
      state    <= state_next;
      n        <= n_next;
      heap_top <= heap_top_next;
      ops      <= ops_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    k   <= k_next;
    cur <= cur_next;
    cm  <= cm_next;
    st  <= st_next;
    pay <= pay_next;
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    k_next        = k;
    n_next        = n;
    heap_top_next = heap_top;
    ops_next      = ops;
    cur_next      = cur;
    cm_next       = cm;
    st_next       = st;
    pay_next      = pay;
    we            = 1'b0;
    waddr         = idx;
    wdata         = rdata;
    raddr         = idx;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;

    case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          cm_next  = cmd;
          idx_next = '0;
          st_next  = ST_OK;
          pay_next = '0;
          case (cmd.kind)
            CMD_ALLOC: state_next = (n == '0) ? S_APPEND : S_A_RD;
            CMD_FREE: begin
              if (n == '0) begin
                st_next    = ST_UNKNOWN;
                state_next = S_DONE;
              end else begin
                state_next = S_F_RD;
              end
            end
            CMD_CLEAR: begin
              n_next        = '0;
              heap_top_next = '0;
              ops_next      = '0;
              state_next    = S_DONE;
            end
            CMD_ZERO: begin
              st_next    = ST_ZERO;
              state_next = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      S_A_RD: state_next = S_A_CHK;

      S_A_CHK: begin
        if (rdata.free && {1'b0, rdata.size} >= cm.need) begin
          cur_next = rdata;
          if ({2'b0, rdata.size} > 23'(cm.need) + 23'(hdr) + 23'd8 && n_w < MAX_W) begin
            if (n_w > idx_p1) begin
              k_next     = n[AW-1:0];
              state_next = S_IS_RD;
            end else begin
              state_next = S_SPLIT1;
            end
          end else begin
            we         = 1'b1;
            wdata      = rdata;
            wdata.free = 1'b0;
            ops_next   = ops + 1'b1;
            pay_next   = 20'(21'(rdata.start) + 21'(hdr));
            state_next = S_DONE;
          end
        end else if (idx_p1 == n_w) begin
          state_next = S_APPEND;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_A_RD;
        end
      end

      S_APPEND: begin
        if (app_end > HEAP_LIM) begin
          st_next = ST_OOM;
        end else if (n_w >= MAX_W) begin
          st_next = ST_FULL;
        end else begin
          we            = 1'b1;
          waddr         = n[AW-1:0];
          wdata.start   = heap_top[19:0];
          wdata.size    = cm.need[20:0];
          wdata.free    = 1'b0;
          n_next        = n + 1'b1;
          heap_top_next = app_end[20:0];
          ops_next      = ops + 1'b1;
          pay_next      = 20'(heap_top + 21'(hdr));
        end
        state_next = S_DONE;
      end

      // open a hole at idx+1 by moving entries up one place
      S_IS_RD: begin
        raddr      = k - 1'b1;
        state_next = S_IS_WR;
      end

      S_IS_WR: begin
        we     = 1'b1;
        waddr  = k;
        wdata  = rdata;
        k_next = k - 1'b1;
        state_next = (k_m1 == idx_p1) ? S_SPLIT1 : S_IS_RD;
      end

      S_SPLIT1: begin
        we          = 1'b1;
        waddr       = idx + 1'b1;
        wdata.start = 20'(21'(cur.start) + 21'(hdr) + cm.need[20:0]);
        wdata.size  = cur.size - cm.need[20:0] - 21'(hdr);
        wdata.free  = 1'b1;
        state_next  = S_SPLIT2;
      end

      S_SPLIT2: begin
        we          = 1'b1;
        wdata.start = cur.start;
        wdata.size  = cm.need[20:0];
        wdata.free  = 1'b0;
        n_next      = n + 1'b1;
        ops_next    = ops + 1'b1;
        pay_next    = 20'(21'(cur.start) + 21'(hdr));
        state_next  = S_DONE;
      end

      S_F_RD: state_next = S_F_CHK;

      S_F_CHK: begin
        if (21'(rdata.start) + 21'(hdr) == {1'b0, cm.offset}) begin
          we         = 1'b1;
          wdata      = rdata;
          wdata.free = 1'b1;
          ops_next   = ops + 1'b1;
          idx_next   = '0;
          state_next = (n_w >= (CW+1)'(2)) ? S_M_RD0 : S_DONE;
        end else if (idx_p1 == n_w) begin
          st_next    = ST_UNKNOWN;
          state_next = S_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_F_RD;
        end
      end

      S_M_RD0: state_next = S_M_LD;

      S_M_LD: begin
        cur_next   = rdata;
        raddr      = idx + 1'b1;
        state_next = S_M_CHK;
      end

      S_M_CHK: begin
        if (cur.free && rdata.free && adj_end == 22'(rdata.start)) begin
          cur_next.size = merged;
          we            = 1'b1;
          wdata.start   = cur.start;
          wdata.size    = merged;
          wdata.free    = 1'b1;
          if (idx_p2 < n_w) begin
            k_next     = idx + 1'b1;
            state_next = S_RM_RD;
          end else begin
            n_next     = n - 1'b1;
            state_next = S_DONE;
          end
        end else begin
          cur_next = rdata;
          if (idx_p2 < n_w) begin
            idx_next   = idx + 1'b1;
            state_next = S_M_NXT;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_M_NXT: begin
        raddr      = idx + 1'b1;
        state_next = S_M_CHK;
      end

      // close the gap left by the absorbed neighbor
      S_RM_RD: begin
        raddr      = k + 1'b1;
        state_next = S_RM_WR;
      end

      S_RM_WR: begin
        we     = 1'b1;
        waddr  = k;
        wdata  = rdata;
        k_next = k + 1'b1;
        if (k_p2 < n_w) begin
          state_next = S_RM_RD;
        end else begin
          n_next     = n - 1'b1;
          state_next = S_M_NXT;
        end
      end

      S_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/first_fit_block_allocator_core.sv]
`timescale 1ns / 1ps
// First-fit heap allocator over a HEAP_BYTES region with a table of up to
// MAX_BLOCKS address-ordered blocks. Push requests (allocate, free, reset
// heap, no-op) through the input queue; pop one result per request from the
// output queue in request order. A request passes the front-end register
// and the command queue to reach the sequencer, which reads and checks each
// table entry it visits. An append adds a write state. A split moves each
// later entry up one place, then writes the free tail and the shortened
// block. A free that matches runs a merge pass over the table, moving
// entries down to close gaps. The result can be popped the cycle after the
// sequencer finishes. The worst case grows with MAX_BLOCKS and is set by
// the table memory (one read, one write port) walked by the sequencer. A
// two-entry command queue between front end and sequencer and a two-entry
// result queue let new requests come in while earlier results wait to be taken.
// header_bytes (cfg_wdata, reset 12) may only be written while idle.
module first_fit_block_allocator_core #(
  parameter int HEAP_BYTES = ffa_pkg::DEF_HEAP_BYTES,
  parameter int MAX_BLOCKS = ffa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  // request side
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      opcode,
  input  logic [20:0]                     request_bytes,
  input  logic [19:0]                     free_offset,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      status,
  output logic [19:0]                     payload_offset,
  output logic [31:0]                     op_count,
  output logic [$clog2(MAX_BLOCKS+1)-1:0] block_count,
  // configuration
  input  logic                            cfg_we,
  input  logic [5:0]                      cfg_wdata
);
  import ffa_pkg::*;

  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int RESW = 3 + 20 + 32 + CW;

  logic [5:0] header_bytes;

  // front end to command queue
  logic       f_push;
  cmd_t       f_cmd;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  cmd_t       q_cmd;

  // sequencer to result queue
  logic          r_push;
  logic          r_full;
  status_t       r_status;
  logic [19:0]   r_payload;
  logic [31:0]   r_ops;
  logic [CW-1:0] r_blocks;
  logic [RESW-1:0] r_word;
  logic [RESW-1:0] o_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HDR_RESET;
    end else if (cfg_we) begin
      header_bytes <= cfg_wdata;
    end
  end

  ffa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .request_bytes (request_bytes),
    .free_offset   (free_offset),
    .cmd_push      (f_push),
    .cmd           (f_cmd),
    .cmd_full      (q_full)
  );

  ffa_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data (f_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  ffa_back #(.HEAP_BYTES(HEAP_BYTES), .MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .hdr         (header_bytes),
    .cmd_empty   (q_empty),
    .cmd_pop     (q_pop),
    .cmd         (q_cmd),
    .res_full    (r_full),
    .res_push    (r_push),
    .res_status  (r_status),
    .res_payload (r_payload),
    .res_ops     (r_ops),
    .res_blocks  (r_blocks)
  );

  // result word: status, payload offset, operation count, table size
  assign r_word = {r_status, r_payload, r_ops, r_blocks};

  ffa_fifo #(.WIDTH(RESW), .DEPTH(2)) u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (r_push),
    .wr_data (r_word),
    .full    (r_full),
    .rd_en   (pop),
    .rd_data (o_word),
    .empty   (empty)
  );

  assign status         = o_word[RESW-1 -: 3];
  assign payload_offset = o_word[RESW-4 -: 20];
  assign op_count       = o_word[CW+31 -: 32];
  assign block_count    = o_word[CW-1:0];

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import ffa_pkg::*;

  localparam int HEAP = 1048576;
  localparam int NBLK = 64;
  localparam int WATCHDOG_LIMIT = 50000;

  typedef struct {
    status_t     st;
    logic [19:0] payload;
    logic [31:0] ops;
    logic [6:0]  nblocks;
  } alloc_result_t;

  // Scoreboard: shadow heap table plus queue of predicted results.
  class heap_scoreboard;
    int unsigned blk_start[NBLK];
    int unsigned blk_size[NBLK];
    bit          blk_free[NBLK];
    int unsigned nblocks;
    int unsigned top;
    bit [31:0]   ops;
    int unsigned hdr = 12;
    alloc_result_t pending_q[$];
    int errors;
    int accepted;
    int checked;
    int status_seen[5];

    function void shift_up(int unsigned idx);
      for (int unsigned k = nblocks; k > idx + 1; k--) begin
        blk_start[k] = blk_start[k-1];
        blk_size[k]  = blk_size[k-1];
        blk_free[k]  = blk_free[k-1];
      end
    endfunction

    function void drop_entry(int unsigned idx);
      for (int unsigned k = idx; k + 1 < nblocks; k++) begin
        blk_start[k] = blk_start[k+1];
        blk_size[k]  = blk_size[k+1];
        blk_free[k]  = blk_free[k+1];
      end
      nblocks--;
    endfunction

    function void coalesce();
      int unsigned i;
      i = 0;
      while (i + 1 < nblocks) begin
        if (blk_free[i] && blk_free[i+1] &&
            blk_start[i] + hdr + blk_size[i] == blk_start[i+1]) begin
          blk_size[i] = (blk_size[i] + hdr + blk_size[i+1]) & 32'h1FFFFF;
          drop_entry(i + 1);
        end else begin
          i++;
        end
      end
    endfunction

    function status_t allocate(int unsigned req, output int unsigned pay);
      int unsigned need;
      int unsigned hit;
      need = (req + 7) & ~32'd7;
      hit = nblocks;
      pay = 0;
      if (need == 0) return ST_ZERO;
      for (int unsigned i = 0; i < nblocks; i++) begin
        if (blk_free[i] && blk_size[i] >= need) begin
          hit = i;
          break;
        end
      end
      if (hit == nblocks) begin
        if (longint'(top) + hdr + need > HEAP) return ST_OOM;
        if (nblocks >= NBLK) return ST_FULL;
        blk_start[hit] = top & 32'hFFFFF;
        blk_size[hit]  = need & 32'h1FFFFF;
        nblocks++;
        top += hdr + need;
      end else if (blk_size[hit] > need + hdr + 8 && nblocks < NBLK) begin
        // split the tail off as a new free block right after the hit
        shift_up(hit);
        blk_start[hit+1] = (blk_start[hit] + hdr + need) & 32'hFFFFF;
        blk_size[hit+1]  = (blk_size[hit] - need - hdr) & 32'h1FFFFF;
        blk_free[hit+1]  = 1;
        nblocks++;
        blk_size[hit] = need;
      end
      blk_free[hit] = 0;
      ops++;
      pay = (blk_start[hit] + hdr) & 32'hFFFFF;
      return ST_OK;
    endfunction

    function status_t release_block(int unsigned off);
      for (int unsigned i = 0; i < nblocks; i++) begin
        if (blk_start[i] + hdr == off) begin
          blk_free[i] = 1;
          ops++;
          coalesce();
          return ST_OK;
        end
      end
      return ST_UNKNOWN;
    endfunction

    function void note_request(opcode_t op, logic [20:0] req, logic [19:0] off);
      alloc_result_t r;
      int unsigned pay;
      pay = 0;
      r.st = ST_OK;
      case (op)
        OPC_ALLOC: r.st = allocate(req, pay);
        OPC_FREE:  r.st = release_block(off);
        OPC_CLEAR: begin
          nblocks = 0;
          top = 0;
          ops = 0;
        end
        default: ;
      endcase
      r.payload = (r.st == ST_OK) ? pay[19:0] : '0;
      r.ops = ops;
      r.nblocks = nblocks[6:0];
      pending_q.push_back(r);
      accepted++;
      status_seen[r.st]++;
    endfunction

    function void check_result(logic [2:0] st, logic [19:0] pay, logic [31:0] oc,
                               logic [6:0] nb);
      alloc_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d payload=%0d", $time, st, pay);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (st !== e.st) begin
        $display("%0t: status exp %0d got %0d", $time, e.st, st);
        errors++;
      end
      if (pay !== e.payload) begin
        $display("%0t: payload_offset exp %0d got %0d", $time, e.payload, pay);
        errors++;
      end
      if (oc !== e.ops) begin
        $display("%0t: op_count exp %0d got %0d", $time, e.ops, oc);
        errors++;
      end
      if (nb !== e.nblocks) begin
        $display("%0t: block_count exp %0d got %0d", $time, e.nblocks, nb);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic [1:0]  opcode = '0;
  logic [20:0] request_bytes = '0;
  logic [19:0] free_offset = '0;
  logic        empty;
  logic        pop = 0;
  logic [2:0]  status;
  logic [19:0] payload_offset;
  logic [31:0] op_count;
  logic [6:0]  block_count;
  logic        cfg_we = 0;
  logic [5:0]  cfg_wdata = '0;

  heap_scoreboard sb = new();
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  bit hold_off = 0;
  bit running = 0;
  int quiet_cycles = 0;

  first_fit_block_allocator_core DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .opcode(opcode), .request_bytes(request_bytes), .free_offset(free_offset),
    .empty(empty), .pop(pop),
    .status(status), .payload_offset(payload_offset),
    .op_count(op_count), .block_count(block_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Result side: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    pop <= !hold_off && ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // Sample transfers at the rising edge; the watchdog counts quiet cycles.
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_result(status, payload_offset, op_count, block_count);
    if ((push && !full) || (pop && !empty) || !running)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(opcode_t op, logic [20:0] req, logic [19:0] off);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      push <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1;
    opcode <= op;
    request_bytes <= req;
    free_offset <= off;
    do @(posedge clk); while (full);
    sb.note_request(op, req, off);
  endtask

  // Free the payload of table entry idx (live or already free).
  task automatic free_entry(int unsigned idx);
    send(OPC_FREE, $urandom, (sb.blk_start[idx] + sb.hdr) & 32'hFFFFF);
  endtask

  task automatic free_any();
    if (sb.nblocks == 0)
      send(OPC_FREE, $urandom, $urandom_range(0, 1048575));
    else
      free_entry($urandom_range(0, sb.nblocks - 1));
  endtask

  task automatic drain_and_write_hdr(logic [5:0] v);
    @(negedge clk);
    push <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    // every result is out, so the sequencer is back in idle
    repeat (4) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.hdr = v;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      send(OPC_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8192)
                                                   : $urandom_range(1, 256),
           $urandom);
    else if (r < 80) free_any();
    else if (r < 85) send(OPC_FREE, $urandom, $urandom_range(0, 1048575));
    else if (r < 88) send(OPC_ALLOC, 0, $urandom);
    else if (r < 90) send(OPC_CLEAR, $urandom, $urandom);
    else if (r < 92) send(OPC_NONE, $urandom, $urandom);
    else send(OPC_ALLOC, $urandom_range(0, 1048576), $urandom);
  endtask

  // Fill the table to its limit, then open holes so that a split is refused
  // and a further append is rejected.
  task automatic fill_table();
    while (sb.nblocks < NBLK && sb.pending_q.size() < 200)
      send(OPC_ALLOC, $urandom_range(1, 64), $urandom);
    send(OPC_ALLOC, 8, $urandom);
    for (int k = 0; k < 3; k++) free_any();
    send(OPC_ALLOC, 8, $urandom);
    send(OPC_ALLOC, 8, $urandom);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && $urandom_range(0, 1)) fill_table();
      else random_item();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    running = 1;

    // Directed: zero size, out of memory, splits, double free, unknown
    // address, idle opcode with all-ones fields, heap reset.
    send(OPC_ALLOC, 0, '0);
    send(OPC_ALLOC, 21'd1048576, '0);
    send(OPC_ALLOC, 21'h0FFFFF, '1);
    send(OPC_ALLOC, 1, '0);
    send(OPC_ALLOC, 100, '0);
    send(OPC_ALLOC, 24, '0);
    free_entry(1);
    free_entry(1);
    send(OPC_ALLOC, 16, '0);
    send(OPC_FREE, '0, 20'hFFFFF);
    send(OPC_FREE, '1, '0);
    send(OPC_NONE, '1, '1);
    free_entry(0);
    free_entry(2);
    send(OPC_CLEAR, '1, '1);
    send(OPC_ALLOC, 8, '0);

    // Long hold-off on the result side while requests keep coming.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
    join_none
    run_phase(0, 0, 40);

    drain_and_write_hdr(6'd8);
    run_phase(80, 0, 100);
    drain_and_write_hdr(6'd32);
    run_phase(0, 80, 100);
    drain_and_write_hdr(6'd20);
    fill_table();
    run_phase(14, 14, 100);
    drain_and_write_hdr(6'd8);
    run_phase(0, 0, 100);

    @(negedge clk);
    push <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("requests %0d, results checked %0d, header settings 12/8/32/20",
             sb.accepted, sb.checked);
    $display("status counts ok %0d zero %0d oom %0d full %0d unknown %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4]);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
